### src/lpd_pkg.sv
// Shared types and constants for the LSB payload deframer.
package lpd_pkg;

    // Header layout: 128 bits, first bit ends up at bit 127
    localparam int HdrBits   = 128;
    localparam int HdrCntW   = 8;
    localparam int PixW      = 8;
    localparam int KW        = 4;
    localparam int KMin      = 1;
    localparam int KMax      = 8;
    localparam int LenW      = 64;
    localparam int MulW      = 32;

    // Queue between front and back
    localparam int QDepth    = 2;
    localparam int QPtrW     = $clog2(QDepth);

    // One queued word: byte, end-of-image mark and the clamped bit count
    typedef struct packed {
        logic [PixW-1:0] pixel;
        logic            last;
        logic [KW-1:0]   k;
    } lpd_item_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } lpd_phase_t;

    typedef enum logic [2:0] {
        B_RUN  = 3'd0,
        B_MUL0 = 3'd1,
        B_MUL1 = 3'd2,
        B_MUL2 = 3'd3,
        B_ADD  = 3'd4,
        B_FIN  = 3'd5
    } lpd_bstate_t;

endpackage

### src/lpd_front.sv
// Front end: config register, input acceptance and bit count clamping.
module lpd_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lpd_pkg::KW-1:0]    cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [lpd_pkg::PixW-1:0]  pixel,
    input  logic                      last_pixel,
    input  logic                      q_full,
    output logic                      push,
    output lpd_pkg::lpd_item_t        item
);

    logic [lpd_pkg::KW-1:0] k_reg;
    logic [lpd_pkg::KW-1:0] k_clamped;

    assign cfg_ready = 1'b1;

    // Bits-per-byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= lpd_pkg::KW'(lpd_pkg::KMin);
        end
        else if (cfg_valid)
        begin
            k_reg <= cfg_data;
        end
    end

    // Zero reads as one, anything above eight as eight
    always_comb
    begin
        if (k_reg < lpd_pkg::KW'(lpd_pkg::KMin))
        begin
            k_clamped = lpd_pkg::KW'(lpd_pkg::KMin);
        end
        else if (k_reg > lpd_pkg::KW'(lpd_pkg::KMax))
        begin
            k_clamped = lpd_pkg::KW'(lpd_pkg::KMax);
        end
        else
        begin
            k_clamped = k_reg;
        end
    end

    // Accept a word whenever the queue has room
    assign in_stall   = q_full;
    assign push       = in_valid && !q_full;
    assign item.pixel = pixel;
    assign item.last  = last_pixel;
    assign item.k     = k_clamped;

endmodule

### src/lpd_queue.sv
// Short queue of classified words between front and back.
module lpd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lpd_pkg::lpd_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output lpd_pkg::lpd_item_t  head_item
);

    lpd_pkg::lpd_item_t              slot_reg [lpd_pkg::QDepth];
    logic [lpd_pkg::QPtrW-1:0]       wr_ptr_reg;
    logic [lpd_pkg::QPtrW-1:0]       rd_ptr_reg;
    logic [lpd_pkg::QPtrW:0]         count_reg;
    logic                            do_pop;

    assign full       = (count_reg == (lpd_pkg::QPtrW+1)'(lpd_pkg::QDepth));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= lpd_pkg::QPtrW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= lpd_pkg::QPtrW'(rd_ptr_reg + 1'b1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/lpd_back.sv
// Back end: header collection, length multiply, payload packing, result register.
module lpd_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  lpd_pkg::lpd_item_t         q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 payload_bits,
    output logic [3:0]                 payload_count,
    output logic                       header_ready,
    output logic [31:0]                sample_rate,
    output logic [15:0]                channel_count,
    output logic [15:0]                bits_per_sample,
    output logic [63:0]                total_frames,
    output logic                       payload_done,
    output logic                       too_short
);

    // Control state
    lpd_pkg::lpd_bstate_t               state_reg, state_next;
    lpd_pkg::lpd_phase_t                phase_reg, phase_next;
    logic [lpd_pkg::HdrCntW-1:0]        cnt_reg, cnt_next;
    logic                               out_valid_reg, out_valid_next;

    // Data state
    logic [lpd_pkg::HdrBits-1:0]        hs_reg, hs_next;
    logic [lpd_pkg::LenW-1:0]           rem_reg, rem_next;
    logic [lpd_pkg::MulW-1:0]           p_reg, p_next;
    logic [lpd_pkg::LenW-1:0]           lo_reg, lo_next;
    logic [lpd_pkg::MulW-1:0]           hi_reg, hi_next;
    lpd_pkg::lpd_item_t                 hold_reg, hold_next;
    logic [lpd_pkg::KW-1:0]             hold_s_reg, hold_s_next;

    // Result registers
    logic [7:0]                         bits_reg, bits_next;
    logic [3:0]                         count_reg, count_next;
    logic                               ready_reg, ready_next;
    logic [lpd_pkg::HdrBits-1:0]        fields_reg, fields_next;
    logic                               done_reg, done_next;
    logic                               short_reg, short_next;

    // Shared multiplier
    logic [lpd_pkg::MulW-1:0]           mul_a, mul_b;
    logic [lpd_pkg::LenW-1:0]           prod;

    // Header path
    logic [lpd_pkg::HdrCntW-1:0]        hdr_sum;
    logic [lpd_pkg::HdrCntW-1:0]        hdr_need;
    logic                               hdr_complete;
    logic [lpd_pkg::KW-1:0]             hdr_take;
    logic [lpd_pkg::PixW-1:0]           rev_pix;
    logic [lpd_pkg::PixW-1:0]           hdr_ins;
    logic [lpd_pkg::HdrBits-1:0]        hs_shifted;

    // Payload path
    lpd_pkg::lpd_item_t                 src_item;
    logic [lpd_pkg::KW-1:0]             src_s;
    logic [lpd_pkg::KW-1:0]             avail;
    logic [lpd_pkg::KW-1:0]             take_n;
    logic [lpd_pkg::PixW-1:0]           src_shifted;
    logic [lpd_pkg::PixW-1:0]           pay_bits;
    logic [lpd_pkg::LenW-1:0]           rem_after;

    logic                               out_free;
    logic                               emit;
    logic                               res_last;
    lpd_pkg::lpd_phase_t                res_phase;

    assign out_free = !out_valid_reg || !out_stall;

    // Multiplier operands per step: ch*bps, then frames low and high halves
    always_comb
    begin
        case (state_reg)
            lpd_pkg::B_MUL0:
            begin
                mul_a = {16'b0, hs_reg[95:80]};
                mul_b = {16'b0, hs_reg[79:64]};
            end
            lpd_pkg::B_MUL1:
            begin
                mul_a = hs_reg[31:0];
                mul_b = p_reg;
            end
            lpd_pkg::B_MUL2:
            begin
                mul_a = hs_reg[63:32];
                mul_b = p_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = lpd_pkg::LenW'(mul_a) * lpd_pkg::LenW'(mul_b);

    // Header bits from the queue head, first bit lands highest
    assign hdr_sum      = cnt_reg + lpd_pkg::HdrCntW'(q_item.k);
    assign hdr_complete = (hdr_sum >= lpd_pkg::HdrCntW'(lpd_pkg::HdrBits));
    assign hdr_need     = lpd_pkg::HdrCntW'(lpd_pkg::HdrBits) - cnt_reg;
    assign hdr_take     = hdr_complete ? hdr_need[lpd_pkg::KW-1:0] : q_item.k;

    always_comb
    begin
        for (int i = 0; i < lpd_pkg::PixW; i++)
        begin
            rev_pix[i] = q_item.pixel[lpd_pkg::PixW-1-i];
        end
    end

    assign hdr_ins    = rev_pix >> (lpd_pkg::KW'(lpd_pkg::PixW) - hdr_take);
    assign hs_shifted = (hs_reg << hdr_take)
                      | {{(lpd_pkg::HdrBits-lpd_pkg::PixW){1'b0}}, hdr_ins};

    // Payload bits: from the head in normal flow, from the held word after a multiply
    assign src_item    = (state_reg == lpd_pkg::B_FIN) ? hold_reg : q_item;
    assign src_s       = (state_reg == lpd_pkg::B_FIN) ? hold_s_reg : '0;
    assign avail       = src_item.k - src_s;
    assign take_n      = (rem_reg < lpd_pkg::LenW'(avail)) ? rem_reg[lpd_pkg::KW-1:0] : avail;
    assign src_shifted = src_item.pixel >> src_s;
    assign rem_after   = rem_reg - lpd_pkg::LenW'(take_n);

    always_comb
    begin
        for (int i = 0; i < lpd_pkg::PixW; i++)
        begin
            pay_bits[i] = src_shifted[i] && (lpd_pkg::KW'(i) < take_n);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        hs_next     = hs_reg;
        rem_next    = rem_reg;
        p_next      = p_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        hold_next   = hold_reg;
        hold_s_next = hold_s_reg;
        q_pop       = 1'b0;
        emit        = 1'b0;
        res_last    = 1'b0;
        res_phase   = phase_reg;
        bits_next   = '0;
        count_next  = '0;
        done_next   = 1'b0;

        case (state_reg)
            lpd_pkg::B_RUN:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    res_last = q_item.last;
                    case (phase_reg)
                        lpd_pkg::PH_HEADER:
                        begin
                            cnt_next = hdr_sum;
                            hs_next  = hs_shifted;
                            if (hdr_complete)
                            begin
                                // rest of this word waits for the length
                                hold_next   = q_item;
                                hold_s_next = hdr_take;
                                state_next  = lpd_pkg::B_MUL0;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        lpd_pkg::PH_PAYLOAD:
                        begin
                            emit       = 1'b1;
                            bits_next  = pay_bits;
                            count_next = take_n;
                            rem_next   = rem_after;
                            if (rem_after == '0)
                            begin
                                done_next = 1'b1;
                                res_phase = lpd_pkg::PH_DONE;
                            end
                        end
                        default:
                        begin
                            // trailing bits dropped
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            lpd_pkg::B_MUL0:
            begin
                p_next     = prod[lpd_pkg::MulW-1:0];
                state_next = lpd_pkg::B_MUL1;
            end
            lpd_pkg::B_MUL1:
            begin
                lo_next    = prod;
                state_next = lpd_pkg::B_MUL2;
            end
            lpd_pkg::B_MUL2:
            begin
                hi_next    = prod[lpd_pkg::MulW-1:0];
                state_next = lpd_pkg::B_ADD;
            end
            lpd_pkg::B_ADD:
            begin
                rem_next   = lo_reg + {hi_reg, {lpd_pkg::MulW{1'b0}}};
                state_next = lpd_pkg::B_FIN;
            end
            lpd_pkg::B_FIN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res_last   = hold_reg.last;
                    bits_next  = pay_bits;
                    count_next = take_n;
                    rem_next   = rem_after;
                    state_next = lpd_pkg::B_RUN;
                    if (rem_after == '0)
                    begin
                        done_next = 1'b1;
                        res_phase = lpd_pkg::PH_DONE;
                    end
                    else
                    begin
                        res_phase = lpd_pkg::PH_PAYLOAD;
                    end
                end
            end
            default:
            begin
                state_next = lpd_pkg::B_RUN;
            end
        endcase

        // Result flags and header fields
        ready_next  = (res_phase != lpd_pkg::PH_HEADER);
        fields_next = ready_next ? hs_reg : '0;
        short_next  = res_last && (res_phase != lpd_pkg::PH_DONE);

        if (emit)
        begin
            phase_next = res_phase;
            if (res_last)
            begin
                // end of image: rearm for the next one
                phase_next = lpd_pkg::PH_HEADER;
                cnt_next   = '0;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpd_pkg::B_RUN;
            phase_reg     <= lpd_pkg::PH_HEADER;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        hs_reg     <= hs_next;
        rem_reg    <= rem_next;
        p_reg      <= p_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        hold_reg   <= hold_next;
        hold_s_reg <= hold_s_next;
        if (emit)
        begin
            bits_reg   <= bits_next;
            count_reg  <= count_next;
            ready_reg  <= ready_next;
            fields_reg <= fields_next;
            done_reg   <= done_next;
            short_reg  <= short_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_bits    = bits_reg;
    assign payload_count   = count_reg;
    assign header_ready    = ready_reg;
    assign sample_rate     = fields_reg[127:96];
    assign channel_count   = fields_reg[95:80];
    assign bits_per_sample = fields_reg[79:64];
    assign total_frames    = fields_reg[63:0];
    assign payload_done    = done_reg;
    assign too_short       = short_reg;

endmodule

### src/lsb_payload_deframer.sv
// Top level of the LSB payload deframer: front end, queue and back end.
//
//  Channel | Handshake                  | Word
//  --------+----------------------------+---------------------------------------------
//  cfg     | cfg_valid / cfg_ready      | cfg_data: low bits per byte
//  in      | in_valid / in_stall        | pixel, last_pixel
//  out     | out_valid / out_stall      | payload_bits, payload_count, header fields, flags
//
// The back end pops a byte whenever the result register is free; one result word per input word.
// The byte that completes the header steps through the back-end states in order: the pop, three passes
// through the shared 32x32 multiplier, one add for the payload length, then the result.
// Reset is asynchronous; no clearing pass, the bit count register resets to one.
// out_stall holds the result register; in_stall rises when the two-entry queue is full.
module lsb_payload_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_bits,
    output logic [3:0]  payload_count,
    output logic        header_ready,
    output logic [31:0] sample_rate,
    output logic [15:0] channel_count,
    output logic [15:0] bits_per_sample,
    output logic [63:0] total_frames,
    output logic        payload_done,
    output logic        too_short
);

    logic               q_full;
    logic               push;
    lpd_pkg::lpd_item_t push_item;
    logic               q_pop;
    logic               q_valid;
    lpd_pkg::lpd_item_t q_item;

    lpd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .last_pixel (last_pixel),
        .q_full     (q_full),
        .push       (push),
        .item       (push_item)
    );

    lpd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_item)
    );

    lpd_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .payload_bits    (payload_bits),
        .payload_count   (payload_count),
        .header_ready    (header_ready),
        .sample_rate     (sample_rate),
        .channel_count   (channel_count),
        .bits_per_sample (bits_per_sample),
        .total_frames    (total_frames),
        .payload_done    (payload_done),
        .too_short       (too_short)
    );

endmodule

### src/lpd_checker.sv
// Port-level checks for the LSB payload deframer and their bind.
module lpd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  payload_bits,
    input logic [3:0]  payload_count,
    input logic        header_ready,
    input logic [31:0] sample_rate,
    input logic [63:0] total_frames,
    input logic        payload_done,
    input logic        too_short
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_bits)
            && $stable(payload_count) && $stable(payload_done))
        else $error("result word changed while stalled");

    // Payload only flows once the header is in
    a_hdr_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !header_ready |-> payload_count == 4'd0 && !payload_done
            && sample_rate == 32'd0 && total_frames == 64'd0)
        else $error("payload or header fields before header complete");

    // Finished payload and a cut-short image exclude each other
    a_done_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_done |-> !too_short)
        else $error("payload_done together with too_short");

    // Unused high bits are zero
    a_bits_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_count < 4'd8 |-> (payload_bits >> payload_count) == 8'd0)
        else $error("payload bits above payload_count");

endmodule

bind lsb_payload_deframer lpd_checker u_lpd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_bits  (payload_bits),
    .payload_count (payload_count),
    .header_ready  (header_ready),
    .sample_rate   (sample_rate),
    .total_frames  (total_frames),
    .payload_done  (payload_done),
    .too_short     (too_short)
);

### tb/lsb_payload_deframer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for lsb_payload_deframer: random images against a bit-level predictor.
module lsb_payload_deframer_test;

    // One result word as seen on the output channel
    typedef struct {
        logic [7:0]  payload_bits;
        logic [3:0]  payload_count;
        logic        header_ready;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] bits_per_sample;
        logic [63:0] total_frames;
        logic        payload_done;
        logic        too_short;
    } deframe_word_t;

    // Predicts one result word per accepted byte and checks the output stream against it
    class deframe_scoreboard;
        deframe_word_t       expected_words[$];
        logic [3:0]          k_reg;
        logic [7:0]          hdr_cnt;
        logic [63:0]         hdr_word [2];
        logic [63:0]         remaining;
        lpd_pkg::lpd_phase_t phase;
        int                  errors;

        function new();
            k_reg  = 4'd1;
            errors = 0;
            clear_image();
        endfunction

        function void clear_image();
            hdr_cnt     = '0;
            hdr_word[0] = '0;
            hdr_word[1] = '0;
            remaining   = '0;
            phase       = lpd_pkg::PH_HEADER;
        endfunction

        function void set_k(logic [3:0] v);
            k_reg = v;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Walk the low K bits of one byte through header, payload or drop
        function void note_pixel(logic [7:0] pix, logic last);
            deframe_word_t w;
            int unsigned   k;
            int unsigned   sel;
            logic          done;
            w    = '{default: '0};
            done = 1'b0;
            k    = 32'(k_reg);
            if (k < 1) k = 1;
            if (k > 8) k = 8;
            for (int b = 0; b < k; b++)
            begin
                if (phase == lpd_pkg::PH_HEADER)
                begin
                    sel = (hdr_cnt < 64) ? 0 : 1;
                    hdr_word[sel] = {hdr_word[sel][62:0], pix[b]};
                    hdr_cnt = hdr_cnt + 8'd1;
                    if (hdr_cnt >= lpd_pkg::HdrBits)
                    begin
                        // length wraps modulo 2^64
                        remaining = hdr_word[1] * hdr_word[0][31:16] * hdr_word[0][15:0];
                        if (remaining == 0)
                        begin
                            phase = lpd_pkg::PH_DONE;
                            done  = 1'b1;
                        end
                        else
                        begin
                            phase = lpd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                else if (phase == lpd_pkg::PH_PAYLOAD)
                begin
                    w.payload_bits[w.payload_count] = pix[b];
                    w.payload_count = w.payload_count + 4'd1;
                    remaining = remaining - 64'd1;
                    if (remaining == 0)
                    begin
                        phase = lpd_pkg::PH_DONE;
                        done  = 1'b1;
                    end
                end
            end
            w.header_ready = (phase != lpd_pkg::PH_HEADER);
            if (w.header_ready)
            begin
                w.sample_rate     = hdr_word[0][63:32];
                w.channel_count   = hdr_word[0][31:16];
                w.bits_per_sample = hdr_word[0][15:0];
                w.total_frames    = hdr_word[1];
            end
            w.payload_done = done;
            w.too_short    = last && (phase != lpd_pkg::PH_DONE);
            expected_words.insert(expected_words.size(), w);
            if (last) clear_image();
        endfunction

        function void cmp_field(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                if (errors < 50)
                    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_word(deframe_word_t got);
            deframe_word_t e;
            if (expected_words.size() == 0)
            begin
                if (errors < 50)
                    $display("%0t: result word with nothing expected", $time);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            cmp_field("payload_bits", 64'(e.payload_bits), 64'(got.payload_bits));
            cmp_field("payload_count", 64'(e.payload_count), 64'(got.payload_count));
            cmp_field("header_ready", 64'(e.header_ready), 64'(got.header_ready));
            cmp_field("sample_rate", 64'(e.sample_rate), 64'(got.sample_rate));
            cmp_field("channel_count", 64'(e.channel_count), 64'(got.channel_count));
            cmp_field("bits_per_sample", 64'(e.bits_per_sample), 64'(got.bits_per_sample));
            cmp_field("total_frames", e.total_frames, got.total_frames);
            cmp_field("payload_done", 64'(e.payload_done), 64'(got.payload_done));
            cmp_field("too_short", 64'(e.too_short), 64'(got.too_short));
        endfunction

        // Leftover expectations count as failures
        function int close();
            if (expected_words.size() != 0)
            begin
                $display("%0t: %0d result words never arrived", $time, expected_words.size());
                errors += expected_words.size();
            end
            return errors;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = 4'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  pixel = 8'd0;
    logic        last_pixel = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  payload_bits;
    logic [3:0]  payload_count;
    logic        header_ready;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] bits_per_sample;
    logic [63:0] total_frames;
    logic        payload_done;
    logic        too_short;

    deframe_scoreboard sb;
    int unsigned       k_eff = 1;
    int unsigned       items_sent = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    logic              hold_on = 1'b0;
    event              hold_start;
    int unsigned       k_plan [12] = '{1, 8, 3, 0, 12, 5, 2, 7, 4, 6, 15, 9};

    lsb_payload_deframer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel           (pixel),
        .last_pixel      (last_pixel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .payload_bits    (payload_bits),
        .payload_count   (payload_count),
        .header_ready    (header_ready),
        .sample_rate     (sample_rate),
        .channel_count   (channel_count),
        .bits_per_sample (bits_per_sample),
        .total_frames    (total_frames),
        .payload_done    (payload_done),
        .too_short       (too_short)
    );

    always #5 clk = ~clk;

    // Output side: check accepted words, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        deframe_word_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.payload_bits    = payload_bits;
            got.payload_count   = payload_count;
            got.header_ready    = header_ready;
            got.sample_rate     = sample_rate;
            got.channel_count   = channel_count;
            got.bits_per_sample = bits_per_sample;
            got.total_frames    = total_frames;
            got.payload_done    = payload_done;
            got.too_short       = too_short;
            sb.check_word(got);
        end
        if (hold_on)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Long receiver hold-off so the input queue fills and stalls
    always
    begin
        @(hold_start);
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one input word, with random idle cycles ahead of it
    task automatic send_pixel(input logic [7:0] p, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        pixel      <= p;
        last_pixel <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_pixel(p, l);
        items_sent++;
    endtask

    // Register write only once every result is back and the back end has settled
    task automatic write_k(input logic [3:0] v);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_k(v);
        k_eff = (v == 0) ? 1 : (v > 8) ? 8 : 32'(v);
    endtask

    // Spread nbits of stream over bytes; header first, everything else random
    task automatic send_image(input logic [127:0] hdr, input int unsigned nbits);
        int unsigned nbytes;
        int unsigned pos;
        logic [7:0]  p;
        nbytes = (nbits + k_eff - 1) / k_eff;
        if (nbytes == 0) nbytes = 1;
        pos = 0;
        for (int i = 0; i < nbytes; i++)
        begin
            p = 8'($urandom);
            for (int b = 0; b < k_eff; b++)
            begin
                if (pos < 128) p[b] = hdr[127 - pos];
                pos++;
            end
            send_pixel(p, i == nbytes - 1);
        end
    endtask

    // Header whose wrapped length product comes out to len
    function automatic logic [127:0] make_header(input logic [63:0] len);
        logic [15:0] ch;
        logic [15:0] bps;
        logic [63:0] prod;
        logic [63:0] inv;
        case ($urandom_range(0, 2))
            0:
            begin
                ch  = 16'd1;
                bps = 16'd1;
            end
            1:
            begin
                ch  = 16'(2 * $urandom_range(0, 3) + 1);
                bps = 16'(2 * $urandom_range(0, 3) + 1);
            end
            default:
            begin
                ch  = 16'($urandom | 1);
                bps = 16'($urandom | 1);
            end
        endcase
        prod = 64'(ch) * 64'(bps);
        // odd inverse modulo 2^64 by Newton steps
        inv = prod;
        repeat (6) inv = inv * (64'd2 - prod * inv);
        return {$urandom, ch, bps, len * inv};
    endfunction

    task automatic send_random_image();
        int unsigned  sel;
        int unsigned  len;
        int unsigned  a;
        int unsigned  b;
        logic [127:0] hdr;
        logic [63:0]  fr;
        sel = $urandom_range(0, 99);
        len = $urandom_range(1, 12 * k_eff);
        hdr = make_header(64'(len));
        if (sel < 45)
        begin
            // complete payload, sometimes with dropped trailing bits
            send_image(hdr, 128 + len + $urandom_range(0, 2 * k_eff));
        end
        else if (sel < 55)
        begin
            // zero-length payload, including a product that wraps to zero
            case ($urandom_range(0, 3))
                0: hdr[79:64] = '0;
                1: hdr[95:80] = '0;
                2: hdr[63:0]  = '0;
                default:
                begin
                    a  = $urandom_range(0, 15);
                    b  = $urandom_range(1, 15);
                    fr = {$urandom, $urandom};
                    fr = fr << (64 - a - b);
                    hdr[95:80] = 16'd1 << a;
                    hdr[79:64] = 16'd1 << b;
                    hdr[63:0]  = fr;
                end
            endcase
            send_image(hdr, 128 + $urandom_range(0, 3 * k_eff));
        end
        else if (sel < 70)
        begin
            // image ends inside the header
            send_image(hdr, $urandom_range(1, 127));
        end
        else if (sel < 78)
        begin
            // image ends inside the payload
            send_image(hdr, (len > 1) ? $urandom_range(129, 127 + len) : 128);
        end
        else if (sel < 86)
        begin
            // wide header fields, huge payload cut short
            hdr[95:64] = $urandom;
            hdr[63:0]  = {$urandom, $urandom};
            send_image(hdr, 128 + $urandom_range(0, 12 * k_eff));
        end
        else
        begin
            hdr = {$urandom, $urandom, $urandom, $urandom};
            send_image(hdr, $urandom_range(1, 200));
        end
    endtask

    // Idle pattern by progress: sender-light, then receiver-light, then none
    task automatic set_idle_mode();
        if (items_sent < 450)
        begin
            send_idle_pct = 33;
            recv_idle_pct = 84;
        end
        else if (items_sent < 900)
        begin
            send_idle_pct = 84;
            recv_idle_pct = 33;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    initial
    begin
        int unsigned phase_start;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all-ones rate, 3-bit payload ending inside a byte, then dropped bits
        write_k(4'd8);
        send_image({32'hFFFF_FFFF, 16'h0001, 16'h0001, 64'd3}, 136);
        // single-byte images cut short in the header
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);

        // Random images across bit-count settings, out-of-range ones included
        for (int i = 0; i < 12; i++)
        begin
            write_k(4'(k_plan[i]));
            if (i == 3 || i == 9) -> hold_start;
            phase_start = items_sent;
            while (items_sent - phase_start < 95)
            begin
                set_idle_mode();
                send_random_image();
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.close() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
